/* hdl/qwt_pkg.sv */
// types, character codes and helpers shared by the quoted word tokeniser
// no dependencies
package qwt_pkg;

	typedef enum logic [1:0] {
		MODE_SKIP = 2'd0,
		MODE_WORD = 2'd1,
		MODE_ESC  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_END    = 2'd1,
		KIND_NOWORD = 2'd2
	} kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;

	// one result of the step logic
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		kind_t      kind;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

/* hdl/qwt_step.sv */
// tokeniser state (scan mode, quoting) and the per-byte decision logic
// depends on qwt_pkg
module qwt_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       byte_s1,
	input  logic             fire,
	output qwt_pkg::res_t    res
);

	qwt_pkg::mode_t mode_q, mode_d, w_mode;
	logic           quo_q, quo_d, w_quo;
	qwt_pkg::res_t  w_res;

	// behaviour of a byte once inside a word
	always_comb begin
		w_mode = qwt_pkg::MODE_WORD;
		w_quo  = quo_q;
		w_res  = '{emit: 1'b1, data: byte_s1, kind: qwt_pkg::KIND_BYTE};
		priority if (byte_s1 == qwt_pkg::CH_NUL) begin
			w_mode = qwt_pkg::MODE_SKIP;
			w_quo  = 1'b0;
			w_res  = '{emit: 1'b1, data: 8'h00, kind: qwt_pkg::KIND_END};
		end else if (byte_s1 == qwt_pkg::CH_BSLASH) begin
			if (quo_q) begin
				w_mode     = qwt_pkg::MODE_ESC;
				w_res.emit = 1'b0;
			end
		end else if (byte_s1 == qwt_pkg::CH_QUOTE) begin
			w_quo      = ~quo_q;
			w_res.emit = 1'b0;
		end else if (!quo_q && qwt_pkg::is_ws(byte_s1)) begin
			w_mode = qwt_pkg::MODE_SKIP;
			w_quo  = 1'b0;
			w_res  = '{emit: 1'b1, data: 8'h00, kind: qwt_pkg::KIND_END};
		end else begin
			// any other byte is kept as it is
			w_mode = qwt_pkg::MODE_WORD;
		end
	end

	always_comb begin
		mode_d = mode_q;
		quo_d  = quo_q;
		res    = '{emit: 1'b0, data: 8'h00, kind: qwt_pkg::KIND_BYTE};
		unique case (mode_q)
			qwt_pkg::MODE_ESC: begin
				if (byte_s1 == qwt_pkg::CH_NUL) begin
					mode_d = qwt_pkg::MODE_SKIP;
					quo_d  = 1'b0;
					res    = '{emit: 1'b1, data: 8'h00, kind: qwt_pkg::KIND_END};
				end else begin
					mode_d = qwt_pkg::MODE_WORD;
					res    = '{emit: 1'b1, data: byte_s1, kind: qwt_pkg::KIND_BYTE};
					if (byte_s1 == qwt_pkg::CH_N)
						res.data = qwt_pkg::CH_LF;
					else if (byte_s1 == qwt_pkg::CH_R)
						res.data = qwt_pkg::CH_CR;
				end
			end
			qwt_pkg::MODE_WORD: begin
				mode_d = w_mode;
				quo_d  = w_quo;
				res    = w_res;
			end
			default: begin
				// skipping leading whitespace, unused code lands here too
				if (byte_s1 == qwt_pkg::CH_NUL) begin
					mode_d = qwt_pkg::MODE_SKIP;
					quo_d  = 1'b0;
					res    = '{emit: 1'b1, data: 8'h00, kind: qwt_pkg::KIND_NOWORD};
				end else if (qwt_pkg::is_ws(byte_s1)) begin
					mode_d = qwt_pkg::MODE_SKIP;
				end else begin
					mode_d = w_mode;
					quo_d  = w_quo;
					res    = w_res;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qwt_pkg::MODE_SKIP;
			quo_q  <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_d;
			quo_q  <= quo_d;
		end
	end

endmodule

/* hdl/qwt_out_fifo.sv */
// two-entry result queue between the step logic and the output channel
// depends on qwt_pkg
module qwt_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    push_data,
	input  qwt_pkg::kind_t push_kind,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic [1:0]    out_kind
);

	logic [7:0]     data_q [2];
	qwt_pkg::kind_t kind_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_byte  = data_q[rd_ptr_q];
	assign out_kind  = 2'(kind_q[rd_ptr_q]);

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
			kind_q[wr_ptr_q] <= push_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/quoted_word_tokenizer_core.sv */
// an accepted item is registered in the input stage, then its result in the queue
// throughput: one item per cycle unless output stalls; one input stage, two-entry queue
// an item is held in the input stage only while its result cannot enter a full queue
// reset (arst_n low, asynchronous): skipping whitespace, quoting off, both stages empty
// depends on qwt_pkg, qwt_step, qwt_out_fifo
module quoted_word_tokenizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          fire;
	logic          full;
	qwt_pkg::res_t res;

	// the stage drains unless it has a result and the queue is full
	assign fire     = valid_s1 && (!res.emit || !full);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= in_byte;
	end

	qwt_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.fire    (fire),
		.res     (res)
	);

	qwt_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && res.emit),
		.push_data (res.data),
		.push_kind (res.kind),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_kind  (out_kind)
	);

endmodule

/* hdl/qwt_checker.sv */
// port-level checks for the quoted word tokeniser, bound to the top level
// depends on qwt_pkg and quoted_word_tokenizer_core
module qwt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] out_kind
);

	// only three result kinds exist
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == qwt_pkg::KIND_BYTE) || (out_kind == qwt_pkg::KIND_END)
			|| (out_kind == qwt_pkg::KIND_NOWORD))
		else $error("illegal result kind");

	// word ends and empty-buffer reports carry a zero byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind != qwt_pkg::KIND_BYTE)) |-> (out_byte == 8'h00))
		else $error("marker result with non-zero byte");

	// a zero byte always ends the buffer, so a word byte is never zero
	a_no_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind == qwt_pkg::KIND_BYTE)) |-> (out_byte != 8'h00))
		else $error("zero word byte");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_kind)))
		else $error("stalled result changed");

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable(in_byte)))
		else $error("waiting input item changed");

endmodule

bind quoted_word_tokenizer_core qwt_checker u_qwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_byte   (in_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.out_kind  (out_kind)
);
